// File: hdl/tlts_pkg.sv
// ----------------------------------------------------------------------------
// Two-level thread scheduler package
// Shared constants, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package tlts_pkg;

	localparam int PROC_SLOTS_DEF   = 8;
	localparam int THREAD_SLOTS_DEF = 8;
	localparam int CPU_COUNT_DEF    = 4;
	localparam int TIME_BITS_DEF    = 64;

	localparam logic [7:0] DEFAULT_SLICE_RST = 8'd50;

	// Command codes carried by an input item.
	localparam logic [1:0] CMD_SCHED  = 2'd0;
	localparam logic [1:0] CMD_THREAD = 2'd1;
	localparam logic [1:0] CMD_PROC   = 2'd2;

	// Process and thread state codes.
	localparam logic [2:0] ST_READY      = 3'd0;
	localparam logic [2:0] ST_RUNNING    = 3'd1;
	localparam logic [2:0] ST_SLEEPING   = 3'd2;
	localparam logic [2:0] ST_BLOCKED    = 3'd3;
	localparam logic [2:0] ST_TERMINATED = 3'd4;

	// Process counter operations.
	localparam logic [2:0] P_HOLD   = 3'd0;
	localparam logic [2:0] P_ZERO   = 3'd1;
	localparam logic [2:0] P_INC    = 3'd2;
	localparam logic [2:0] P_CP     = 3'd3;
	localparam logic [2:0] P_CP_INC = 3'd4;

	// Thread counter operations.
	localparam logic [2:0] T_HOLD   = 3'd0;
	localparam logic [2:0] T_ZERO   = 3'd1;
	localparam logic [2:0] T_INC    = 3'd2;
	localparam logic [2:0] T_CT     = 3'd3;
	localparam logic [2:0] T_CT_INC = 3'd4;

	typedef struct packed {
		logic       capture;
		logic       do_write;
		logic       res_ack;
		logic       res_oor;
		logic       res_idle;
		logic       pick;
		logic       pick_same;
		logic       dem_proc;
		logic       dem_thr;
		logic       free_proc;
		logic       acc_clear;
		logic       clean_eval;
		logic       derive;
		logic       wake_eval;
		logic       load_out;
		logic [2:0] p_op;
		logic [2:0] t_op;
	} tlts_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       cpu_ok;
		logic       cur_any;
		logic       pp;
		logic       p_ready;
		logic       p_term;
		logic       thr_last;
		logic       proc_last;
		logic       derive_ok;
		logic       runnable;
		logic       can_same;
		logic       cp_present;
		logic       cp_last;
	} tlts_stat_t;

endpackage

// File: hdl/tlts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/tlts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences writes, demotion, the per-process maintenance pass and the search.
// ----------------------------------------------------------------------------
module tlts_ctrl import tlts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  tlts_stat_t stat,
	output tlts_cmd_t  ctl
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_WRITE  = 4'd2;
	localparam logic [3:0] S_DEM_RD = 4'd3;
	localparam logic [3:0] S_DEM_EV = 4'd4;
	localparam logic [3:0] S_MP     = 4'd5;
	localparam logic [3:0] S_CL_RD  = 4'd6;
	localparam logic [3:0] S_CL_EV  = 4'd7;
	localparam logic [3:0] S_DERIVE = 4'd8;
	localparam logic [3:0] S_WK_RD  = 4'd9;
	localparam logic [3:0] S_WK_EV  = 4'd10;
	localparam logic [3:0] S_SEL    = 4'd11;
	localparam logic [3:0] S_SP     = 4'd12;
	localparam logic [3:0] S_SR_RD  = 4'd13;
	localparam logic [3:0] S_SR_EV  = 4'd14;
	localparam logic [3:0] S_DONE   = 4'd15;

	localparam logic [1:0] PH_SAME  = 2'd0;
	localparam logic [1:0] PH_LATER = 2'd1;
	localparam logic [1:0] PH_WRAP  = 2'd2;
	localparam logic [1:0] PH_FIRST = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       out_valid_q;
	logic       do_skip;
	logic       maint_next;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl        = '0;
		ctl.p_op   = P_HOLD;
		ctl.t_op   = T_HOLD;
		state_d    = state_q;
		phase_d    = phase_q;
		do_skip    = 1'b0;
		maint_next = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.cmd == CMD_THREAD || stat.cmd == CMD_PROC) begin
					state_d = S_WRITE;
				end else if (stat.cmd != CMD_SCHED) begin
					ctl.res_ack = 1'b1;
					state_d     = S_DONE;
				end else if (!stat.cpu_ok) begin
					ctl.res_oor = 1'b1;
					state_d     = S_DONE;
				end else if (stat.cur_any) begin
					ctl.p_op = P_CP;
					ctl.t_op = T_CT;
					phase_d  = PH_SAME;
					state_d  = S_DEM_RD;
				end else begin
					ctl.p_op = P_ZERO;
					phase_d  = PH_FIRST;
					state_d  = S_SP;
				end
			end
			S_WRITE: begin
				ctl.do_write = 1'b1;
				ctl.res_ack  = 1'b1;
				state_d      = S_DONE;
			end
			S_DEM_RD: begin
				ctl.dem_proc = 1'b1;
				state_d      = S_DEM_EV;
			end
			S_DEM_EV: begin
				ctl.dem_thr = 1'b1;
				ctl.p_op    = P_ZERO;
				state_d     = S_MP;
			end
			S_MP: begin
				if (!stat.pp) begin
					maint_next = 1'b1;
				end else if (stat.p_term) begin
					ctl.free_proc = 1'b1;
					maint_next    = 1'b1;
				end else begin
					ctl.t_op      = T_ZERO;
					ctl.acc_clear = 1'b1;
					state_d       = S_CL_RD;
				end
			end
			S_CL_RD: state_d = S_CL_EV;
			S_CL_EV: begin
				ctl.clean_eval = 1'b1;
				if (!stat.thr_last) begin
					ctl.t_op = T_INC;
					state_d  = S_CL_RD;
				end else if (phase_q == PH_FIRST) begin
					do_skip = 1'b1;
				end else begin
					state_d = S_DERIVE;
				end
			end
			S_DERIVE: begin
				ctl.derive = 1'b1;
				if (stat.derive_ok) begin
					ctl.t_op = T_ZERO;
					state_d  = S_WK_RD;
				end else begin
					maint_next = 1'b1;
				end
			end
			S_WK_RD: state_d = S_WK_EV;
			S_WK_EV: begin
				ctl.wake_eval = 1'b1;
				if (!stat.thr_last) begin
					ctl.t_op = T_INC;
					state_d  = S_WK_RD;
				end else begin
					maint_next = 1'b1;
				end
			end
			S_SEL: begin
				if (stat.can_same) begin
					ctl.p_op = P_CP;
					ctl.t_op = T_CT_INC;
					phase_d  = PH_SAME;
					state_d  = S_SR_RD;
				end else if (stat.cp_present && !stat.cp_last) begin
					ctl.p_op = P_CP_INC;
					phase_d  = PH_LATER;
					state_d  = S_SP;
				end else begin
					ctl.p_op = P_ZERO;
					phase_d  = PH_WRAP;
					state_d  = S_SP;
				end
			end
			S_SP: begin
				if (phase_q == PH_FIRST) begin
					if (!stat.pp) begin
						do_skip = 1'b1;
					end else if (!stat.p_ready) begin
						if (stat.p_term) begin
							ctl.free_proc = 1'b1;
							do_skip       = 1'b1;
						end else begin
							ctl.t_op      = T_ZERO;
							ctl.acc_clear = 1'b1;
							state_d       = S_CL_RD;
						end
					end else begin
						ctl.t_op = T_ZERO;
						state_d  = S_SR_RD;
					end
				end else if (stat.pp && stat.p_ready) begin
					ctl.t_op = T_ZERO;
					state_d  = S_SR_RD;
				end else begin
					do_skip = 1'b1;
				end
			end
			S_SR_RD: state_d = S_SR_EV;
			S_SR_EV: begin
				if (stat.runnable) begin
					ctl.pick      = 1'b1;
					ctl.pick_same = (phase_q == PH_SAME) || (phase_q == PH_FIRST);
					state_d       = S_DONE;
				end else if (!stat.thr_last) begin
					ctl.t_op = T_INC;
					state_d  = S_SR_RD;
				end else if (phase_q == PH_SAME) begin
					if (!stat.cp_last) begin
						ctl.p_op = P_CP_INC;
						phase_d  = PH_LATER;
					end else begin
						ctl.p_op = P_ZERO;
						phase_d  = PH_WRAP;
					end
					state_d = S_SP;
				end else begin
					do_skip = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// Move past a process that yields nothing during the search.
		if (do_skip) begin
			if (!stat.proc_last) begin
				ctl.p_op = P_INC;
				state_d  = S_SP;
			end else if (phase_q == PH_LATER) begin
				ctl.p_op = P_ZERO;
				phase_d  = PH_WRAP;
				state_d  = S_SP;
			end else begin
				ctl.res_idle = 1'b1;
				state_d      = S_DONE;
			end
		end

		// Step to the next process of the maintenance pass.
		if (maint_next) begin
			if (stat.proc_last) begin
				state_d = S_SEL;
			end else begin
				ctl.p_op = P_INC;
				state_d  = S_MP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SAME;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/tlts_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Process and thread tables, per-CPU current entries, scan counters, result.
// ----------------------------------------------------------------------------
module tlts_datapath import tlts_pkg::*; #(
	parameter int PROC_SLOTS   = PROC_SLOTS_DEF,
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
	parameter int CPU_COUNT    = CPU_COUNT_DEF,
	parameter int TIME_BITS    = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tlts_cmd_t   ctl,
	output tlts_stat_t  stat,
	input  logic [1:0]  cmd,
	input  logic [1:0]  cpu_id,
	input  logic [2:0]  proc_index,
	input  logic [2:0]  thread_index,
	input  logic        entry_valid,
	input  logic [2:0]  state_value,
	input  logic [3:0]  affinity_mask,
	input  logic [63:0] wake_time,
	input  logic [7:0]  priority_req,
	input  logic [63:0] now,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output logic [2:0]  sel_proc,
	output logic [2:0]  sel_thread,
	output logic        is_idle,
	output logic        same_process,
	output logic [7:0]  time_slice,
	output logic        is_decision
);

	localparam int TSLOTS = PROC_SLOTS * THREAD_SLOTS;
	localparam int PW     = $clog2(PROC_SLOTS);
	localparam int TW     = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int CW     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int AW     = $clog2(TSLOTS);
	localparam int WORD_W = 3 + 4 + TIME_BITS + 8;

	// Tables and per-CPU state.
	logic [PROC_SLOTS-1:0] pp_q;
	logic [2:0]            ps_q [PROC_SLOTS];
	logic [TSLOTS-1:0]     tp_q;
	logic [CPU_COUNT-1:0]  cur_pres_q;
	logic [CPU_COUNT-1:0]  cur_idle_q;
	logic [PW-1:0]         cur_proc_q [CPU_COUNT];
	logic [TW-1:0]         cur_thr_q  [CPU_COUNT];
	logic [7:0]            dslice_q;
	logic [PW-1:0]         p_q;
	logic [TW-1:0]         t_q;

	// Captured item.
	logic [1:0]           cmd_q;
	logic [1:0]           cpu_q;
	logic [2:0]           proc_q;
	logic [2:0]           thr_q;
	logic                 valid_q;
	logic [2:0]           stv_q;
	logic [3:0]           aff_q;
	logic [TIME_BITS-1:0] wake_q;
	logic [7:0]           pri_q;
	logic [TIME_BITS-1:0] now_q;

	// Per-process accumulators.
	logic [1:0] cnt_q;
	logic [2:0] last_q;
	logic       sleep_q;
	logic [2:0] pstash_q;

	// Result held until the output register is free.
	logic [2:0] res_proc_q, res_thr_q;
	logic       res_idle_q, res_same_q, res_dec_q;
	logic [7:0] res_slice_q;

	logic [WORD_W-1:0]    rd_data, wr_data;
	logic [2:0]           rd_state, new_state, derived;
	logic [3:0]           rd_aff;
	logic [TIME_BITS-1:0] rd_wake;
	logic [7:0]           rd_pri;
	logic [AW-1:0]        cur_idx, w_idx, cp_idx, ram_waddr;
	logic [CW-1:0]        cpu_idx;
	logic [PW-1:0]        cp;
	logic [TW-1:0]        ct;
	logic                 have, pi_ok, ti_ok, thr_wr, dem_hit, wake_hit, ram_we;

	assign rd_state = rd_data[WORD_W-1 -: 3];
	assign rd_aff   = rd_data[WORD_W-4 -: 4];
	assign rd_wake  = rd_data[8 +: TIME_BITS];
	assign rd_pri   = rd_data[7:0];

	assign cpu_idx = CW'(cpu_q);
	assign cp      = cur_proc_q[cpu_idx];
	assign ct      = cur_thr_q[cpu_idx];
	assign have    = cur_pres_q[cpu_idx];
	assign cur_idx = AW'(int'(p_q) * THREAD_SLOTS + int'(t_q));
	assign cp_idx  = AW'(int'(cp) * THREAD_SLOTS + int'(ct));
	assign w_idx   = AW'(int'(proc_q) * THREAD_SLOTS + int'(thr_q));
	assign pi_ok   = int'(proc_q) < PROC_SLOTS;
	assign ti_ok   = int'(thr_q) < THREAD_SLOTS;

	assign thr_wr   = ctl.do_write && (cmd_q == CMD_THREAD) && pi_ok && ti_ok;
	assign dem_hit  = ctl.dem_thr && have && tp_q[cur_idx] && (rd_state == ST_RUNNING);
	assign wake_hit = tp_q[cur_idx] && (rd_state == ST_SLEEPING) && (rd_wake < now_q);
	assign ram_we   = thr_wr || dem_hit || (ctl.wake_eval && wake_hit) || ctl.pick;

	always_comb begin
		if (ctl.pick) begin
			new_state = ST_RUNNING;
		end else begin
			new_state = ST_READY;
		end
		if (ctl.do_write) begin
			wr_data   = {stv_q, aff_q, wake_q, pri_q};
			ram_waddr = w_idx;
		end else begin
			wr_data   = {new_state, rd_aff, rd_wake, rd_pri};
			ram_waddr = cur_idx;
		end
	end

	// Process state derived from its surviving threads.
	always_comb begin
		if (cnt_q == 2'd1) begin
			derived = last_q;
		end else if (sleep_q) begin
			derived = ST_SLEEPING;
		end else if (ps_q[p_q] == ST_SLEEPING) begin
			derived = ST_READY;
		end else begin
			derived = ps_q[p_q];
		end
	end

	always_comb begin
		stat            = '0;
		stat.cmd        = cmd_q;
		stat.cpu_ok     = int'(cpu_q) < CPU_COUNT;
		stat.cur_any    = cur_pres_q[cpu_idx] || cur_idle_q[cpu_idx];
		stat.pp         = pp_q[p_q];
		stat.p_ready    = ps_q[p_q] == ST_READY;
		stat.p_term     = ps_q[p_q] == ST_TERMINATED;
		stat.thr_last   = t_q == TW'(THREAD_SLOTS - 1);
		stat.proc_last  = p_q == PW'(PROC_SLOTS - 1);
		stat.derive_ok  = (derived == ST_READY) || (derived == ST_SLEEPING) ||
			(derived == ST_BLOCKED);
		stat.runnable   = tp_q[cur_idx] && (rd_state == ST_READY) && rd_aff[cpu_q];
		stat.cp_present = have && pp_q[cp];
		stat.can_same   = have && pp_q[cp] && tp_q[cp_idx] && (ct != TW'(THREAD_SLOTS - 1));
		stat.cp_last    = cp == PW'(PROC_SLOTS - 1);
	end

	tlts_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TSLOTS)
	) u_thr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_data),
		.raddr (cur_idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q       <= '0;
			ps_q       <= '{default: '0};
			tp_q       <= '0;
			cur_pres_q <= '0;
			cur_idle_q <= '0;
			cur_proc_q <= '{default: '0};
			cur_thr_q  <= '{default: '0};
			dslice_q   <= DEFAULT_SLICE_RST;
			p_q        <= '0;
			t_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				dslice_q <= cfg_wr_data;
			end

			case (ctl.p_op)
				P_ZERO:   p_q <= '0;
				P_INC:    p_q <= p_q + 1'b1;
				P_CP:     p_q <= cp;
				P_CP_INC: p_q <= cp + 1'b1;
				default:  p_q <= p_q;
			endcase
			case (ctl.t_op)
				T_ZERO:   t_q <= '0;
				T_INC:    t_q <= t_q + 1'b1;
				T_CT:     t_q <= ct;
				T_CT_INC: t_q <= ct + 1'b1;
				default:  t_q <= t_q;
			endcase

			if (thr_wr) begin
				tp_q[w_idx] <= valid_q;
			end
			if (ctl.do_write && (cmd_q == CMD_PROC) && pi_ok) begin
				ps_q[PW'(proc_q)] <= stv_q;
				pp_q[PW'(proc_q)] <= valid_q;
				if (!valid_q) begin
					for (int t = 0; t < THREAD_SLOTS; t++) begin
						tp_q[AW'(int'(proc_q) * THREAD_SLOTS + t)] <= 1'b0;
					end
				end
			end

			if (ctl.dem_proc && have && pp_q[cp] && (ps_q[cp] == ST_RUNNING)) begin
				ps_q[cp] <= ST_READY;
			end
			if (ctl.free_proc) begin
				pp_q[p_q] <= 1'b0;
				for (int t = 0; t < THREAD_SLOTS; t++) begin
					tp_q[AW'(int'(p_q) * THREAD_SLOTS + t)] <= 1'b0;
				end
			end
			if (ctl.clean_eval && tp_q[cur_idx] && (rd_state == ST_TERMINATED)) begin
				tp_q[cur_idx] <= 1'b0;
			end
			if (ctl.derive) begin
				ps_q[p_q] <= derived;
			end
			if (ctl.wake_eval && wake_hit && (pstash_q == ST_SLEEPING)) begin
				ps_q[p_q] <= ST_READY;
			end

			if (ctl.pick) begin
				ps_q[p_q]           <= ST_RUNNING;
				cur_pres_q[cpu_idx] <= 1'b1;
				cur_idle_q[cpu_idx] <= 1'b0;
				cur_proc_q[cpu_idx] <= p_q;
				cur_thr_q[cpu_idx]  <= t_q;
			end
			if (ctl.res_idle) begin
				cur_pres_q[cpu_idx] <= 1'b0;
				cur_idle_q[cpu_idx] <= 1'b1;
				cur_proc_q[cpu_idx] <= '0;
				cur_thr_q[cpu_idx]  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd;
			cpu_q   <= cpu_id;
			proc_q  <= proc_index;
			thr_q   <= thread_index;
			valid_q <= entry_valid;
			stv_q   <= state_value;
			aff_q   <= affinity_mask;
			wake_q  <= wake_time[TIME_BITS-1:0];
			pri_q   <= priority_req;
			now_q   <= now[TIME_BITS-1:0];
		end

		if (ctl.acc_clear) begin
			cnt_q   <= 2'd0;
			sleep_q <= 1'b1;
		end else if (ctl.clean_eval && tp_q[cur_idx] && (rd_state != ST_TERMINATED)) begin
			if (cnt_q != 2'd2) begin
				cnt_q <= cnt_q + 2'd1;
			end
			last_q <= rd_state;
			if (rd_state != ST_SLEEPING) begin
				sleep_q <= 1'b0;
			end
		end
		if (ctl.derive) begin
			pstash_q <= derived;
		end

		if (ctl.res_ack) begin
			res_proc_q  <= '0;
			res_thr_q   <= '0;
			res_idle_q  <= 1'b0;
			res_same_q  <= 1'b0;
			res_slice_q <= '0;
			res_dec_q   <= 1'b0;
		end else if (ctl.res_oor || ctl.res_idle) begin
			res_proc_q  <= '0;
			res_thr_q   <= '0;
			res_idle_q  <= 1'b1;
			res_same_q  <= 1'b1;
			res_slice_q <= dslice_q;
			res_dec_q   <= 1'b1;
		end else if (ctl.pick) begin
			res_proc_q  <= 3'(p_q);
			res_thr_q   <= 3'(t_q);
			res_idle_q  <= 1'b0;
			res_same_q  <= ctl.pick_same;
			res_slice_q <= (rd_pri != 8'd0) ? rd_pri : dslice_q;
			res_dec_q   <= 1'b1;
		end

		if (ctl.load_out) begin
			sel_proc     <= res_proc_q;
			sel_thread   <= res_thr_q;
			is_idle      <= res_idle_q;
			same_process <= res_same_q;
			time_slice   <= res_slice_q;
			is_decision  <= res_dec_q;
		end
	end

endmodule

// File: hdl/two_level_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Two-level thread scheduler
// Process/thread slot table with write commands and per-CPU schedule picks.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Contents
//  in        input      in_valid/in_ready     command, indexes, entry, now
//  out       output     out_valid/out_ready   choice, idle, slice, decision
//  cfg       input      cfg_wr_en             default time slice
//
// One item is in flight at a time. A write passes through the decode, write
// and done states before its result is loaded. A schedule call for a CPU that
// has a pick or idle result runs a maintenance pass of up to two scans per
// process, each taking a read and an evaluate step per thread slot of the
// registered-read thread RAM, then a search; a first call searches at once.
// Reset clears every table flag at once; there is no clearing pass.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module two_level_thread_scheduler import tlts_pkg::*; #(
	parameter int PROC_SLOTS   = PROC_SLOTS_DEF,
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
	parameter int CPU_COUNT    = CPU_COUNT_DEF,
	parameter int TIME_BITS    = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [1:0]  cpu_id,
	input  logic [2:0]  proc_index,
	input  logic [2:0]  thread_index,
	input  logic        entry_valid,
	input  logic [2:0]  state_value,
	input  logic [3:0]  affinity_mask,
	input  logic [63:0] wake_time,
	input  logic [7:0]  priority_req,
	input  logic [63:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  sel_proc,
	output logic [2:0]  sel_thread,
	output logic        is_idle,
	output logic        same_process,
	output logic [7:0]  time_slice,
	output logic        is_decision,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	// The controller walks the process and thread slots; the datapath holds
	// the tables and answers with status flags for the slot under the counters.
	tlts_cmd_t  ctl;
	tlts_stat_t stat;

	tlts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tlts_datapath #(
		.PROC_SLOTS   (PROC_SLOTS),
		.THREAD_SLOTS (THREAD_SLOTS),
		.CPU_COUNT    (CPU_COUNT),
		.TIME_BITS    (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.cpu_id        (cpu_id),
		.proc_index    (proc_index),
		.thread_index  (thread_index),
		.entry_valid   (entry_valid),
		.state_value   (state_value),
		.affinity_mask (affinity_mask),
		.wake_time     (wake_time),
		.priority_req  (priority_req),
		.now           (now),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.sel_proc      (sel_proc),
		.sel_thread    (sel_thread),
		.is_idle       (is_idle),
		.same_process  (same_process),
		.time_slice    (time_slice),
		.is_decision   (is_decision)
	);

endmodule

// File: tb/sched_checker.sv
// ----------------------------------------------------------------------------
// Scheduler decision checker
// Watches the input, output and configuration ports and keeps its own copy of
// the process and thread tables. Each accepted input works out the expected
// answer, and each accepted output is compared against the oldest one.
// ----------------------------------------------------------------------------
module sched_checker import tlts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [1:0]  cpu_id,
	input  logic [2:0]  proc_index,
	input  logic [2:0]  thread_index,
	input  logic        entry_valid,
	input  logic [2:0]  state_value,
	input  logic [3:0]  affinity_mask,
	input  logic [63:0] wake_time,
	input  logic [7:0]  priority_req,
	input  logic [63:0] now,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  sel_proc,
	input  logic [2:0]  sel_thread,
	input  logic        is_idle,
	input  logic        same_process,
	input  logic [7:0]  time_slice,
	input  logic        is_decision,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [2:0] proc_sel;
		logic [2:0] thr_sel;
		logic       idle;
		logic       same;
		logic [7:0] slice;
		logic       decision;
	} decision_t;

	decision_t   expected_q[$];
	logic [7:0]  slice_dflt;
	logic        proc_live [8];
	logic [2:0]  proc_st   [8];
	logic        thr_live  [64];
	logic [2:0]  thr_st    [64];
	logic [3:0]  thr_aff   [64];
	logic [63:0] thr_wake  [64];
	logic [7:0]  thr_prio  [64];
	logic        cpu_has   [4];
	logic        cpu_idle  [4];
	int          cpu_proc  [4];
	int          cpu_thr   [4];

	function automatic bit can_run(int i, int c);
		return thr_live[i] && thr_st[i] == ST_READY && thr_aff[i][c];
	endfunction

	function automatic void drop_process(int p);
		proc_live[p] = 1'b0;
		for (int t = 0; t < 8; t++) thr_live[p*8+t] = 1'b0;
	endfunction

	function automatic void tidy_process(int p);
		if (proc_st[p] == ST_TERMINATED) begin
			drop_process(p);
			return;
		end
		for (int t = 0; t < 8; t++)
			if (thr_live[p*8+t] && thr_st[p*8+t] == ST_TERMINATED) thr_live[p*8+t] = 1'b0;
	endfunction

	function automatic int first_runnable(int p, int from, int c);
		for (int t = from; t < 8; t++)
			if (can_run(p*8+t, c)) return t;
		return -1;
	endfunction

	// A process with one thread mirrors it; with all threads asleep (or
	// finished) it sleeps; a sleeping process with a thread awake is ready.
	function automatic void derive_proc_states();
		int cnt;
		int last;
		bit all_sleep;
		for (int p = 0; p < 8; p++) begin
			if (!proc_live[p] || proc_st[p] == ST_TERMINATED) continue;
			cnt = 0;
			last = 0;
			all_sleep = 1'b1;
			for (int t = 0; t < 8; t++) begin
				if (!thr_live[p*8+t]) continue;
				cnt++;
				last = p*8+t;
				if (thr_st[p*8+t] != ST_TERMINATED && thr_st[p*8+t] != ST_SLEEPING)
					all_sleep = 1'b0;
			end
			if (cnt == 1) proc_st[p] = thr_st[last];
			else if (all_sleep) proc_st[p] = ST_SLEEPING;
			else if (proc_st[p] == ST_SLEEPING) proc_st[p] = ST_READY;
		end
	endfunction

	function automatic void wake_expired(logic [63:0] t_now);
		logic [2:0] ps;
		for (int p = 0; p < 8; p++) begin
			ps = proc_st[p];
			if (!proc_live[p]) continue;
			if (ps != ST_READY && ps != ST_SLEEPING && ps != ST_BLOCKED) continue;
			for (int t = 0; t < 8; t++) begin
				if (!thr_live[p*8+t] || thr_st[p*8+t] != ST_SLEEPING) continue;
				if (thr_wake[p*8+t] < t_now) begin
					if (ps == ST_SLEEPING) proc_st[p] = ST_READY;
					thr_st[p*8+t] = ST_READY;
					thr_wake[p*8+t] = '0;
				end
			end
		end
	endfunction

	function automatic decision_t schedule_cpu(int c, logic [63:0] t_now);
		decision_t r;
		int sp;
		int st;
		int cp;
		int ct;
		bit same;
		bit have;
		r = '0;
		r.decision = 1'b1;
		sp = -1;
		st = -1;
		same = 1'b0;
		if (!cpu_has[c] && !cpu_idle[c]) begin
			// First pick on this CPU: only a partial clean-up along the way.
			same = 1'b1;
			for (int p = 0; p < 8 && sp < 0; p++) begin
				if (!proc_live[p]) continue;
				if (proc_st[p] != ST_READY) begin
					tidy_process(p);
					continue;
				end
				st = first_runnable(p, 0, c);
				if (st >= 0) sp = p;
			end
		end else begin
			cp = cpu_proc[c];
			ct = cpu_thr[c];
			have = cpu_has[c];
			if (have && proc_live[cp] && proc_st[cp] == ST_RUNNING) proc_st[cp] = ST_READY;
			if (have && thr_live[cp*8+ct] && thr_st[cp*8+ct] == ST_RUNNING)
				thr_st[cp*8+ct] = ST_READY;
			for (int p = 0; p < 8; p++)
				if (proc_live[p]) tidy_process(p);
			derive_proc_states();
			wake_expired(t_now);
			if (have && proc_live[cp] && thr_live[cp*8+ct]) begin
				st = first_runnable(cp, ct + 1, c);
				if (st >= 0) begin
					sp = cp;
					same = 1'b1;
				end
			end
			if (sp < 0 && have && proc_live[cp]) begin
				for (int p = cp + 1; p < 8 && sp < 0; p++) begin
					if (!proc_live[p] || proc_st[p] != ST_READY) continue;
					st = first_runnable(p, 0, c);
					if (st >= 0) sp = p;
				end
			end
			for (int p = 0; p < 8 && sp < 0; p++) begin
				if (!proc_live[p] || proc_st[p] != ST_READY) continue;
				st = first_runnable(p, 0, c);
				if (st >= 0) sp = p;
			end
		end
		if (sp < 0) begin
			cpu_has[c] = 1'b0;
			cpu_idle[c] = 1'b1;
			cpu_proc[c] = 0;
			cpu_thr[c] = 0;
			r.idle = 1'b1;
			r.same = 1'b1;
			r.slice = slice_dflt;
			return r;
		end
		proc_st[sp] = ST_RUNNING;
		thr_st[sp*8+st] = ST_RUNNING;
		cpu_has[c] = 1'b1;
		cpu_idle[c] = 1'b0;
		cpu_proc[c] = sp;
		cpu_thr[c] = st;
		r.proc_sel = sp[2:0];
		r.thr_sel = st[2:0];
		r.same = same;
		r.slice = thr_prio[sp*8+st] != 0 ? thr_prio[sp*8+st] : slice_dflt;
		return r;
	endfunction

	function automatic decision_t predict_item();
		int i;
		i = proc_index * 8 + thread_index;
		if (cmd == CMD_THREAD) begin
			thr_live[i] = entry_valid;
			thr_st[i] = state_value;
			thr_aff[i] = affinity_mask;
			thr_wake[i] = wake_time;
			thr_prio[i] = priority_req;
			return '0;
		end
		if (cmd == CMD_PROC) begin
			if (entry_valid) proc_live[proc_index] = 1'b1;
			else drop_process(proc_index);
			proc_st[proc_index] = state_value;
			return '0;
		end
		if (cmd != CMD_SCHED) return '0;
		return schedule_cpu(cpu_id, now);
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		decision_t got;
		decision_t want;
		if (!arst_n) begin
			expected_q.delete();
			fail_count <= 0;
			slice_dflt = DEFAULT_SLICE_RST;
			for (int p = 0; p < 8; p++) begin
				proc_live[p] = 1'b0;
				proc_st[p] = ST_READY;
			end
			for (int i = 0; i < 64; i++) begin
				thr_live[i] = 1'b0;
				thr_st[i] = ST_READY;
				thr_aff[i] = '0;
				thr_wake[i] = '0;
				thr_prio[i] = '0;
			end
			for (int c = 0; c < 4; c++) begin
				cpu_has[c] = 1'b0;
				cpu_idle[c] = 1'b0;
				cpu_proc[c] = 0;
				cpu_thr[c] = 0;
			end
		end else begin
			if (out_valid && out_ready) begin
				got = '{sel_proc, sel_thread, is_idle, same_process, time_slice, is_decision};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) expected_q.insert(expected_q.size(), predict_item());
			if (cfg_wr_en) slice_dflt = cfg_wr_data;
		end
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Two-level thread scheduler testbench
// Drives directed and random table writes and schedule calls through the
// block, varies back-pressure on both channels across phases, and lets the
// checker module predict and compare every decision and acknowledgement.
// ----------------------------------------------------------------------------
module tb;
	import tlts_pkg::*;

	localparam int PHASE_ITEMS = 300;
	localparam int STALL_LIMIT = 40000;

	// Command code with no meaning, and a state code that matches no state.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] ST_OTHER   = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [1:0]  cpu_id;
	logic [2:0]  proc_index;
	logic [2:0]  thread_index;
	logic        entry_valid;
	logic [2:0]  state_value;
	logic [3:0]  affinity_mask;
	logic [63:0] wake_time;
	logic [7:0]  priority_req;
	logic [63:0] now;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  sel_proc;
	logic [2:0]  sel_thread;
	logic        is_idle;
	logic        same_process;
	logic [7:0]  time_slice;
	logic        is_decision;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	int          fail_count;
	int          pending;

	// Percent chance, per cycle, that the sender idles or the receiver stalls.
	int          send_gap_pct;
	int          recv_stall_pct;
	logic        long_hold;
	int          quiet_cycles;

	two_level_thread_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .cpu_id(cpu_id), .proc_index(proc_index), .thread_index(thread_index),
		.entry_valid(entry_valid), .state_value(state_value), .affinity_mask(affinity_mask),
		.wake_time(wake_time), .priority_req(priority_req), .now(now),
		.out_valid(out_valid), .out_ready(out_ready),
		.sel_proc(sel_proc), .sel_thread(sel_thread), .is_idle(is_idle),
		.same_process(same_process), .time_slice(time_slice), .is_decision(is_decision),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	sched_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .cpu_id(cpu_id), .proc_index(proc_index), .thread_index(thread_index),
		.entry_valid(entry_valid), .state_value(state_value), .affinity_mask(affinity_mask),
		.wake_time(wake_time), .priority_req(priority_req), .now(now),
		.out_valid(out_valid), .out_ready(out_ready),
		.sel_proc(sel_proc), .sel_thread(sel_thread), .is_idle(is_idle),
		.same_process(same_process), .time_slice(time_slice), .is_decision(is_decision),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Receiver: random stalls at the current rate, plus one long hold-off on
	// request. The long hold is counted here so the sender keeps offering
	// items meanwhile and the block backs up into its input.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_taken) begin
				hold_left = 1500;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("** two_level_thread_scheduler: FAILED **");
			$finish;
		end
	end

	// One transfer on the input channel. Called at a falling edge and returns
	// at a falling edge; valid stays high if the next call follows at once.
	task automatic send(logic [1:0] c, logic [1:0] cpu, logic [2:0] p, logic [2:0] t,
			logic v, logic [2:0] st, logic [3:0] aff, logic [63:0] wk,
			logic [7:0] prio, logic [63:0] tnow);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		cpu_id        <= cpu;
		proc_index    <= p;
		thread_index  <= t;
		entry_valid   <= v;
		state_value   <= st;
		affinity_mask <= aff;
		wake_time     <= wk;
		priority_req  <= prio;
		now           <= tnow;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic put_thread(logic [2:0] p, logic [2:0] t, logic v, logic [2:0] st,
			logic [3:0] aff, logic [63:0] wk, logic [7:0] prio);
		send(CMD_THREAD, 2'd0, p, t, v, st, aff, wk, prio, 64'd0);
	endtask

	task automatic put_proc(logic [2:0] p, logic v, logic [2:0] st);
		send(CMD_PROC, 2'd0, p, 3'd0, v, st, 4'h0, 64'd0, 8'd0, 64'd0);
	endtask

	task automatic run_sched(logic [1:0] cpu, logic [63:0] tnow);
		send(CMD_SCHED, cpu, 3'd0, 3'd0, 1'b0, ST_READY, 4'h0, 64'd0, 8'd0, tnow);
	endtask

	// Drop valid and wait until every outstanding answer has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_slice(logic [7:0] val);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [63:0] pick_time();
		if ($urandom_range(3) == 0) return {$urandom, $urandom};
		return 64'($urandom_range(1000));
	endfunction

	// Random traffic: mostly table fills with ready threads and schedule
	// calls, so the search reaches deep; the rest are removals, odd states
	// and the unused command code.
	task automatic random_item();
		int r;
		logic [2:0] st;
		r = $urandom_range(99);
		st = ($urandom_range(99) < 60) ? ST_READY : 3'($urandom_range(7));
		if (r < 42) begin
			run_sched(2'($urandom_range(3)), pick_time());
		end else if (r < 75) begin
			put_thread(3'($urandom_range(7)), 3'($urandom_range(7)), 1'b1, st,
				($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'hF,
				pick_time(), ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255)));
		end else if (r < 88) begin
			put_proc(3'($urandom_range(7)), 1'b1,
				($urandom_range(99) < 70) ? ST_READY : 3'($urandom_range(7)));
		end else if (r < 93) begin
			put_thread(3'($urandom_range(7)), 3'($urandom_range(7)), 1'b0, st,
				4'($urandom_range(15)), pick_time(), 8'($urandom_range(255)));
		end else if (r < 97) begin
			put_proc(3'($urandom_range(7)), 1'b0, 3'($urandom_range(7)));
		end else begin
			send(CMD_UNUSED, 2'($urandom_range(3)), 3'($urandom_range(7)),
				3'($urandom_range(7)), 1'($urandom_range(1)), 3'($urandom_range(7)),
				4'($urandom_range(15)), {$urandom, $urandom}, 8'($urandom_range(255)),
				{$urandom, $urandom});
		end
	endtask

	initial begin
		int gap_pct  [4] = '{0, 60, 0, 23};
		int stall_pct[4] = '{0, 0, 60, 23};
		logic [7:0] slice_set[4];
		in_valid = 1'b0;
		cmd = CMD_SCHED;
		cpu_id = '0;
		proc_index = '0;
		thread_index = '0;
		entry_valid = 1'b0;
		state_value = '0;
		affinity_mask = '0;
		wake_time = '0;
		priority_req = '0;
		now = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, at the reset default slice.
		run_sched(2'd0, 64'd0);                         // empty table: idle
		put_proc(3'd0, 1'b1, ST_READY);
		put_thread(3'd0, 3'd0, 1'b1, ST_READY, 4'hF, 64'd0, 8'd0);
		put_thread(3'd0, 3'd7, 1'b1, ST_READY, 4'h8, 64'd5, 8'd255);
		put_proc(3'd7, 1'b1, ST_READY);
		put_thread(3'd7, 3'd3, 1'b1, ST_READY, 4'h1, '1, 8'd1);
		put_proc(3'd2, 1'b1, ST_TERMINATED);            // freed by a maintenance pass
		put_proc(3'd4, 1'b1, ST_READY);                 // no threads: sleeps
		put_proc(3'd5, 1'b1, ST_READY);
		put_thread(3'd5, 3'd1, 1'b1, ST_SLEEPING, 4'hF, 64'd100, 8'd7);
		put_thread(3'd5, 3'd2, 1'b1, ST_TERMINATED, 4'hF, 64'd0, 8'd9);
		put_thread(3'd5, 3'd4, 1'b1, ST_OTHER, 4'hF, '1, 8'd9);
		run_sched(2'd0, 64'd0);                         // first pick
		run_sched(2'd0, 64'd50);                        // moves on to another process
		run_sched(2'd0, '1);                            // sleeper wakes
		run_sched(2'd3, 64'd0);
		run_sched(2'd3, 64'd0);
		run_sched(2'd1, 64'd1);
		run_sched(2'd2, '1);
		put_thread(3'd0, 3'd0, 1'b0, ST_READY, 4'h0, 64'd0, 8'd0);
		put_proc(3'd7, 1'b0, ST_READY);                 // removal frees its threads
		send(CMD_UNUSED, 2'd3, 3'd7, 3'd7, 1'b1, ST_OTHER, 4'hF, '1, 8'd255, '1);
		run_sched(2'd0, '1);
		run_sched(2'd1, 64'd0);

		slice_set = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), DEFAULT_SLICE_RST};
		for (int ph = 0; ph < 4; ph++) begin
			set_slice(slice_set[ph]);
			send_gap_pct = gap_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Phase of free flow: a long receiver hold-off part way in.
				if (ph == 0 && n == 100) long_hold = 1'b1;
				// Stretches without idling inside the stalled phases.
				if (ph != 0 && n == 200) begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				if (ph == 2 && n == 150) drain();
				random_item();
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (800) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("** two_level_thread_scheduler: PASSED **");
		end else begin
			$display("** two_level_thread_scheduler: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/tlts_pkg.sv
hdl/tlts_ram.sv
hdl/tlts_ctrl.sv
hdl/tlts_datapath.sv
hdl/two_level_thread_scheduler.sv
tb/sched_checker.sv
tb/tb.sv
